/* design/luo_pkg.sv */
package luo_pkg;

    // micro-operations issued by the sequencer
    typedef enum logic [4:0] {
        OP_NONE,
        OP_START,
        OP_DIV_NX,
        OP_DIV_NY,
        OP_MUL_XX,
        OP_MUL_YY,
        OP_MUL_XY,
        OP_MUL_R4,
        OP_MUL_R6,
        OP_MUL_K1,
        OP_MUL_K2,
        OP_MUL_K3,
        OP_MUL_P1A,
        OP_MUL_P2A,
        OP_MUL_P1B,
        OP_MUL_P2B,
        OP_PIX_X,
        OP_PIX_Y,
        OP_FIN,
        OP_DIV_RX,
        OP_DIV_RY,
        OP_LOAD
    } op_t;

    typedef struct packed {
        op_t op;
    } cmd_t;

    typedef struct packed {
        logic div_done;
        logic den_pos;
        logic out_free;
    } sts_t;

    typedef struct packed {
        logic [23:0] focal_x;
        logic [23:0] focal_y;
        logic [15:0] cx;
        logic [15:0] cy;
        logic [23:0] k1;
        logic [23:0] k2;
        logic [23:0] k3;
        logic [23:0] p1;
        logic [23:0] p2;
    } cfg_t;

    localparam int NUM_MUL_OPS = 12;

endpackage

/* design/luo_div.sv */
module luo_div (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [63:0]        num,
    input  logic [31:0]        den,
    input  logic               neg,
    output logic               busy,
    output logic               done,
    output logic signed [31:0] quo,
    output logic               ovf
);

    logic        busy_reg;
    logic        done_reg;
    logic [4:0]  cnt_reg;
    logic        neg_reg;
    logic        big_reg;
    logic [31:0] rem_reg;
    logic [31:0] lo_reg;
    logic [31:0] den_reg;
    logic [32:0] rem_shift;
    logic        fits;

    // one quotient bit per cycle
    assign rem_shift = {rem_reg, lo_reg[31]};
    assign fits      = (rem_shift >= {1'b0, den_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                neg_reg <= neg;
                den_reg <= den;
                cnt_reg <= '0;
                if (num == 64'd0)
                begin
                    big_reg  <= 1'b0;
                    lo_reg   <= '0;
                    done_reg <= 1'b1;
                end
                else if (num[63:32] >= den)
                begin
                    big_reg  <= 1'b1;
                    lo_reg   <= '0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    big_reg  <= 1'b0;
                    rem_reg  <= num[63:32];
                    lo_reg   <= num[31:0];
                    busy_reg <= 1'b1;
                end
            end
            else if (busy_reg)
            begin
                rem_reg <= fits ? 32'(rem_shift - {1'b0, den_reg}) : rem_shift[31:0];
                lo_reg  <= {lo_reg[30:0], fits};
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'd31)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // sign and saturation of the quotient
    always_comb
    begin
        ovf = 1'b0;
        quo = '0;
        if (big_reg)
        begin
            ovf = 1'b1;
            quo = neg_reg ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end
        else if (neg_reg)
        begin
            if (lo_reg > 32'h8000_0000)
            begin
                ovf = 1'b1;
                quo = 32'sh8000_0000;
            end
            else
            begin
                quo = $signed(-lo_reg);
            end
        end
        else
        begin
            if (lo_reg > 32'h7FFF_FFFF)
            begin
                ovf = 1'b1;
                quo = 32'sh7FFF_FFFF;
            end
            else
            begin
                quo = $signed(lo_reg);
            end
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;

endmodule

/* design/luo_datapath.sv */
module luo_datapath
    import luo_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  cmd_t               cmd,
    output sts_t               sts,
    input  cfg_t               cfg,
    input  logic [15:0]        x_pixel,
    input  logic [15:0]        y_pixel,
    input  logic               out_stall,
    output logic               out_valid,
    output logic signed [19:0] corrected_x,
    output logic signed [19:0] corrected_y,
    output logic               out_of_range
);

    typedef struct packed {
        logic               ovf;
        logic signed [31:0] val;
    } sat_t;

    localparam logic signed [67:0] S32MAX = 68'sd2147483647;
    localparam logic signed [67:0] S32MIN = -68'sd2147483648;
    localparam logic signed [67:0] QONE   = 68'sd268435456;
    localparam logic signed [67:0] RND27  = 68'sd134217728;
    localparam logic signed [67:0] RND31  = 68'sd2147483648;
    localparam logic signed [35:0] OUTMAX = 36'sd524287;
    localparam logic signed [35:0] OUTMIN = -36'sd524288;

    function automatic sat_t sat32(input logic signed [67:0] v);
        sat_t r;
        begin
            r.ovf = 1'b0;
            r.val = v[31:0];
            if (v > S32MAX)
            begin
                r.ovf = 1'b1;
                r.val = 32'sh7FFF_FFFF;
            end
            else if (v < S32MIN)
            begin
                r.ovf = 1'b1;
                r.val = 32'sh8000_0000;
            end
            return r;
        end
    endfunction

    // working registers, Q4.28
    logic [15:0]        xin_reg, yin_reg;
    logic signed [31:0] x0_reg, y0_reg, x_reg, y_reg;
    logic signed [31:0] xx_reg, yy_reg, r2_reg, r4_reg, r6_reg;
    logic signed [31:0] xy2_reg, tx_reg, ty_reg;
    logic signed [34:0] den_acc_reg;
    logic signed [31:0] den_reg, nx_reg, ny_reg;
    logic signed [31:0] dx_reg, dy_reg;
    logic signed [19:0] pixx_reg, pixy_reg;
    logic               flag_reg;
    logic signed [63:0] prod_reg;
    op_t                wb_op_reg;
    logic               wb_valid_reg;
    op_t                ddest_reg;
    logic               out_valid_reg;
    logic signed [19:0] corrected_x_reg, corrected_y_reg;
    logic               out_of_range_reg;

    logic signed [31:0] k1, k2, k3, p1, p2;
    logic signed [31:0] ma, mb;
    logic               is_mul;
    logic               div_start;
    logic [63:0]        div_num;
    logic [31:0]        div_den;
    logic               div_neg;
    logic               div_busy;
    logic               div_done;
    logic signed [31:0] div_quo;
    logic               div_ovf;

    logic signed [16:0] dnx, dny;
    logic [16:0]        dmag;
    logic [31:0]        nmag;
    logic signed [67:0] qsh;
    sat_t               q, r2s, xy2s, txs, tys, dxs, dys, dens, nxs, nys;
    logic signed [67:0] pix_sum;
    logic signed [35:0] pix_r;
    logic signed [19:0] pix_c;
    logic               pix_ovf;

    assign k1 = $signed({cfg.k1, 8'h00});
    assign k2 = $signed({cfg.k2, 8'h00});
    assign k3 = $signed({cfg.k3, 8'h00});
    assign p1 = $signed({cfg.p1, 8'h00});
    assign p2 = $signed({cfg.p2, 8'h00});

    // shared multiplier operand select
    always_comb
    begin
        ma     = '0;
        mb     = '0;
        is_mul = 1'b1;
        case (cmd.op)
            OP_MUL_XX:  begin ma = x_reg;  mb = x_reg;   end
            OP_MUL_YY:  begin ma = y_reg;  mb = y_reg;   end
            OP_MUL_XY:  begin ma = x_reg;  mb = y_reg;   end
            OP_MUL_R4:  begin ma = r2_reg; mb = r2_reg;  end
            OP_MUL_R6:  begin ma = r4_reg; mb = r2_reg;  end
            OP_MUL_K1:  begin ma = k1;     mb = r2_reg;  end
            OP_MUL_K2:  begin ma = k2;     mb = r4_reg;  end
            OP_MUL_K3:  begin ma = k3;     mb = r6_reg;  end
            OP_MUL_P1A: begin ma = p1;     mb = xy2_reg; end
            OP_MUL_P2A: begin ma = p2;     mb = tx_reg;  end
            OP_MUL_P1B: begin ma = p1;     mb = ty_reg;  end
            OP_MUL_P2B: begin ma = p2;     mb = xy2_reg; end
            OP_PIX_X:   begin ma = x_reg;  mb = $signed({8'h00, cfg.focal_x}); end
            OP_PIX_Y:   begin ma = y_reg;  mb = $signed({8'h00, cfg.focal_y}); end
            default:    is_mul = 1'b0;
        endcase
    end

    // divider operand select
    always_comb
    begin
        dnx       = $signed({1'b0, xin_reg}) - $signed({1'b0, cfg.cx});
        dny       = $signed({1'b0, yin_reg}) - $signed({1'b0, cfg.cy});
        dmag      = '0;
        nmag      = '0;
        div_start = 1'b1;
        div_num   = '0;
        div_den   = '0;
        div_neg   = 1'b0;
        case (cmd.op)
            OP_DIV_NX:
            begin
                div_neg = dnx[16];
                dmag    = dnx[16] ? 17'(-dnx) : dnx;
                div_num = {15'd0, dmag, 32'd0};
                div_den = {8'h00, cfg.focal_x};
            end
            OP_DIV_NY:
            begin
                div_neg = dny[16];
                dmag    = dny[16] ? 17'(-dny) : dny;
                div_num = {15'd0, dmag, 32'd0};
                div_den = {8'h00, cfg.focal_y};
            end
            OP_DIV_RX:
            begin
                div_neg = nx_reg[31];
                nmag    = nx_reg[31] ? 32'(-nx_reg) : nx_reg;
                div_num = {4'd0, nmag, 28'd0};
                div_den = den_reg;
            end
            OP_DIV_RY:
            begin
                div_neg = ny_reg[31];
                nmag    = ny_reg[31] ? 32'(-ny_reg) : ny_reg;
                div_num = {4'd0, nmag, 28'd0};
                div_den = den_reg;
            end
            default: div_start = 1'b0;
        endcase
    end

    luo_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .neg   (div_neg),
        .busy  (div_busy),
        .done  (div_done),
        .quo   (div_quo),
        .ovf   (div_ovf)
    );

    // rounding, saturation and the sums that follow a product
    always_comb
    begin
        qsh     = (68'(prod_reg) + RND27) >>> 28;
        q       = sat32(qsh);
        r2s     = sat32(68'(xx_reg) + 68'(q.val));
        xy2s    = sat32(68'(q.val) + 68'(q.val));
        txs     = sat32(68'(r2_reg) + 68'(xx_reg) + 68'(xx_reg));
        tys     = sat32(68'(r2_reg) + 68'(yy_reg) + 68'(yy_reg));
        dxs     = sat32(68'(dx_reg) + 68'(q.val));
        dys     = sat32(68'(dy_reg) + 68'(q.val));
        dens    = sat32(68'(den_acc_reg));
        nxs     = sat32(68'(x0_reg) - 68'(dx_reg));
        nys     = sat32(68'(y0_reg) - 68'(dy_reg));
        pix_sum = 68'(prod_reg) + RND31 + $signed({20'd0,
                  (wb_op_reg == OP_PIX_Y) ? cfg.cy : cfg.cx, 32'd0});
        pix_r   = pix_sum[67:32];
        pix_ovf = 1'b1;
        if (pix_r > OUTMAX)
        begin
            pix_c = OUTMAX[19:0];
        end
        else if (pix_r < OUTMIN)
        begin
            pix_c = OUTMIN[19:0];
        end
        else
        begin
            pix_c   = pix_r[19:0];
            pix_ovf = 1'b0;
        end
    end

    // multiplier and writeback registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wb_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            flag_reg      <= 1'b0;
        end
        else
        begin
            wb_valid_reg <= is_mul;
            if (is_mul)
            begin
                prod_reg  <= ma * mb;
                wb_op_reg <= cmd.op;
            end
            if (div_start)
            begin
                ddest_reg <= cmd.op;
            end

            if (div_done)
            begin
                flag_reg <= flag_reg | div_ovf;
                case (ddest_reg)
                    OP_DIV_NX: begin x0_reg <= div_quo; x_reg <= div_quo; end
                    OP_DIV_NY: begin y0_reg <= div_quo; y_reg <= div_quo; end
                    OP_DIV_RX: x_reg <= div_quo;
                    OP_DIV_RY: y_reg <= div_quo;
                    default:   ;
                endcase
            end

            if (wb_valid_reg)
            begin
                case (wb_op_reg)
                    OP_MUL_XX:
                    begin
                        xx_reg   <= q.val;
                        flag_reg <= flag_reg | q.ovf;
                    end
                    OP_MUL_YY:
                    begin
                        yy_reg   <= q.val;
                        r2_reg   <= r2s.val;
                        flag_reg <= flag_reg | q.ovf | r2s.ovf;
                    end
                    OP_MUL_XY:
                    begin
                        xy2_reg  <= xy2s.val;
                        tx_reg   <= txs.val;
                        ty_reg   <= tys.val;
                        flag_reg <= flag_reg | q.ovf | xy2s.ovf | txs.ovf | tys.ovf;
                    end
                    OP_MUL_R4:
                    begin
                        r4_reg   <= q.val;
                        flag_reg <= flag_reg | q.ovf;
                    end
                    OP_MUL_R6:
                    begin
                        r6_reg   <= q.val;
                        flag_reg <= flag_reg | q.ovf;
                    end
                    OP_MUL_K1:
                    begin
                        den_acc_reg <= 35'(QONE) + 35'(q.val);
                        flag_reg    <= flag_reg | q.ovf;
                    end
                    OP_MUL_K2, OP_MUL_K3:
                    begin
                        den_acc_reg <= den_acc_reg + 35'(q.val);
                        flag_reg    <= flag_reg | q.ovf;
                    end
                    OP_MUL_P1A:
                    begin
                        dx_reg   <= q.val;
                        flag_reg <= flag_reg | q.ovf;
                    end
                    OP_MUL_P2A:
                    begin
                        dx_reg   <= dxs.val;
                        flag_reg <= flag_reg | q.ovf | dxs.ovf;
                    end
                    OP_MUL_P1B:
                    begin
                        dy_reg   <= q.val;
                        flag_reg <= flag_reg | q.ovf;
                    end
                    OP_MUL_P2B:
                    begin
                        dy_reg   <= dys.val;
                        flag_reg <= flag_reg | q.ovf | dys.ovf;
                    end
                    OP_PIX_X:
                    begin
                        pixx_reg <= pix_c;
                        flag_reg <= flag_reg | pix_ovf;
                    end
                    OP_PIX_Y:
                    begin
                        pixy_reg <= pix_c;
                        flag_reg <= flag_reg | pix_ovf;
                    end
                    default: ;
                endcase
            end

            case (cmd.op)
                OP_START:
                begin
                    xin_reg  <= x_pixel;
                    yin_reg  <= y_pixel;
                    flag_reg <= 1'b0;
                end
                OP_FIN:
                begin
                    den_reg  <= dens.val;
                    nx_reg   <= nxs.val;
                    ny_reg   <= nys.val;
                    flag_reg <= flag_reg | dens.ovf | nxs.ovf | nys.ovf | !sts.den_pos;
                    if (!sts.den_pos)
                    begin
                        x_reg <= nxs.val;
                        y_reg <= nys.val;
                    end
                end
                default: ;
            endcase

            // output register
            if (cmd.op == OP_LOAD)
            begin
                out_valid_reg    <= 1'b1;
                corrected_x_reg  <= pixx_reg;
                corrected_y_reg  <= pixy_reg;
                out_of_range_reg <= flag_reg;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign sts.div_done = div_done;
    assign sts.den_pos  = (dens.val > 32'sd0);
    assign sts.out_free = !out_valid_reg || !out_stall;

    assign out_valid    = out_valid_reg;
    assign corrected_x  = corrected_x_reg;
    assign corrected_y  = corrected_y_reg;
    assign out_of_range = out_of_range_reg;

`ifndef NO_ASSERTIONS
    a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_DIV_NX || cmd.op == OP_DIV_NY || cmd.op == OP_DIV_RX ||
         cmd.op == OP_DIV_RY) |-> !div_busy)
        else $error("divider started while busy");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_LOAD) |-> sts.out_free)
        else $error("output word overwritten");

    a_wb_follows: assert property (@(posedge clk) disable iff (!rst_n)
        is_mul |=> wb_valid_reg)
        else $error("product not written back");

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> !wb_valid_reg)
        else $error("divider and multiplier writeback collide");
`endif

endmodule

/* design/luo_ctrl.sv */
module luo_ctrl
    import luo_pkg::*;
#(
    parameter int ITERATIONS = 10
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_stall,
    input  sts_t sts,
    output cmd_t cmd
);

    localparam int ITW = (ITERATIONS > 1) ? $clog2(ITERATIONS) : 1;

    typedef enum logic [4:0] {
        S_IDLE, S_NX, S_NX_W, S_NY, S_NY_W, S_MUL, S_MUL_W, S_FIN,
        S_RX, S_RX_W, S_RY, S_RY_W, S_PX, S_PX_W, S_PY, S_PY_W, S_OUT
    } state_t;

    state_t           state_reg;
    logic [3:0]       idx_reg;
    logic [ITW-1:0]   it_reg;
    logic             last_it;
    op_t              mul_op;

    // multiply order within one iteration
    always_comb
    begin
        case (idx_reg)
            4'd0:    mul_op = OP_MUL_XX;
            4'd1:    mul_op = OP_MUL_YY;
            4'd2:    mul_op = OP_MUL_XY;
            4'd3:    mul_op = OP_MUL_R4;
            4'd4:    mul_op = OP_MUL_R6;
            4'd5:    mul_op = OP_MUL_K1;
            4'd6:    mul_op = OP_MUL_K2;
            4'd7:    mul_op = OP_MUL_K3;
            4'd8:    mul_op = OP_MUL_P1A;
            4'd9:    mul_op = OP_MUL_P2A;
            4'd10:   mul_op = OP_MUL_P1B;
            4'd11:   mul_op = OP_MUL_P2B;
            default: mul_op = OP_NONE;
        endcase
    end

    assign last_it = (it_reg == ITW'(ITERATIONS - 1));

    // command decode
    always_comb
    begin
        case (state_reg)
            S_IDLE:  cmd.op = in_valid ? OP_START : OP_NONE;
            S_NX:    cmd.op = OP_DIV_NX;
            S_NY:    cmd.op = OP_DIV_NY;
            S_MUL:   cmd.op = mul_op;
            S_FIN:   cmd.op = OP_FIN;
            S_RX:    cmd.op = OP_DIV_RX;
            S_RY:    cmd.op = OP_DIV_RY;
            S_PX:    cmd.op = OP_PIX_X;
            S_PY:    cmd.op = OP_PIX_Y;
            S_OUT:   cmd.op = sts.out_free ? OP_LOAD : OP_NONE;
            default: cmd.op = OP_NONE;
        endcase
    end

    assign in_stall = (state_reg != S_IDLE);

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            idx_reg   <= '0;
            it_reg    <= '0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        state_reg <= S_NX;
                    end
                end
                S_NX:   state_reg <= S_NX_W;
                S_NX_W:
                begin
                    if (sts.div_done)
                    begin
                        state_reg <= S_NY;
                    end
                end
                S_NY:   state_reg <= S_NY_W;
                S_NY_W:
                begin
                    if (sts.div_done)
                    begin
                        state_reg <= S_MUL;
                        idx_reg   <= '0;
                        it_reg    <= '0;
                    end
                end
                S_MUL:  state_reg <= S_MUL_W;
                S_MUL_W:
                begin
                    if (idx_reg == 4'(NUM_MUL_OPS - 1))
                    begin
                        idx_reg   <= '0;
                        state_reg <= S_FIN;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + 4'd1;
                        state_reg <= S_MUL;
                    end
                end
                S_FIN:
                begin
                    if (sts.den_pos)
                    begin
                        state_reg <= S_RX;
                    end
                    else if (last_it)
                    begin
                        state_reg <= S_PX;
                    end
                    else
                    begin
                        it_reg    <= it_reg + 1'b1;
                        state_reg <= S_MUL;
                    end
                end
                S_RX:   state_reg <= S_RX_W;
                S_RX_W:
                begin
                    if (sts.div_done)
                    begin
                        state_reg <= S_RY;
                    end
                end
                S_RY:   state_reg <= S_RY_W;
                S_RY_W:
                begin
                    if (sts.div_done)
                    begin
                        if (last_it)
                        begin
                            state_reg <= S_PX;
                        end
                        else
                        begin
                            it_reg    <= it_reg + 1'b1;
                            state_reg <= S_MUL;
                        end
                    end
                end
                S_PX:   state_reg <= S_PX_W;
                S_PX_W: state_reg <= S_PY;
                S_PY:   state_reg <= S_PY_W;
                S_PY_W: state_reg <= S_OUT;
                S_OUT:
                begin
                    if (sts.out_free)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    a_iter_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MUL) |-> (it_reg <= ITW'(ITERATIONS - 1)))
        else $error("iteration count overrun");

    a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_START) |=> (state_reg == S_NX))
        else $error("accepted word not started");

    a_idx_reset: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIN) |-> (idx_reg == 4'd0))
        else $error("multiply index not rewound");
`endif

endmodule

/* design/lens_point_undistort.sv */
// lens_point_undistort: inverse radial/tangential lens correction of one point
// input channel: x_pixel, y_pixel (unsigned Q12.4) with in_valid / in_stall;
//   a word is taken when in_valid is high and in_stall low
// output channel: corrected_x, corrected_y (signed Q15.4, saturated) and
//   out_of_range, with out_valid / out_stall
// configuration: APB-style port, registers at byte address 4*i (focal_x,
//   focal_y, principal_point, k1, k2, k3, p1, p2); write only while idle
// one word is in flight at a time; in_stall is high from acceptance until the
//   result is placed in the output register
// each iteration runs twelve products through one shared 32x32 multiplier and
//   two 32-step restoring divisions; the two normalising divisions come before
//   the first iteration; a division with a zero numerator or a saturating one
//   ends without its 32 steps, and a non-positive denominator skips both divisions
// a stalled output word holds; the next word can be accepted and worked on
//   while it waits, and the new result waits until the register frees
// reset clears the sequencer and the output valid and sets the configuration
//   registers to their defaults (focal lengths 1.0 pixel, everything else zero)
module lens_point_undistort
    import luo_pkg::*;
#(
    parameter int ITERATIONS = 10
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [15:0]        x_pixel,
    input  logic [15:0]        y_pixel,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [19:0] corrected_x,
    output logic signed [19:0] corrected_y,
    output logic               out_of_range
);

    localparam logic [2:0] REG_FOCAL_X = 3'd0;
    localparam logic [2:0] REG_FOCAL_Y = 3'd1;
    localparam logic [2:0] REG_PP      = 3'd2;
    localparam logic [2:0] REG_K1      = 3'd3;
    localparam logic [2:0] REG_K2      = 3'd4;
    localparam logic [2:0] REG_K3      = 3'd5;
    localparam logic [2:0] REG_P1      = 3'd6;
    localparam logic [2:0] REG_P2      = 3'd7;

    cfg_t        cfg_reg;
    logic        wr_en;
    logic [2:0]  reg_idx;
    cmd_t        cmd;
    sts_t        sts;

    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[4:2];
    assign pready  = 1'b1;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.focal_x <= 24'd256;
            cfg_reg.focal_y <= 24'd256;
            cfg_reg.cx      <= '0;
            cfg_reg.cy      <= '0;
            cfg_reg.k1      <= '0;
            cfg_reg.k2      <= '0;
            cfg_reg.k3      <= '0;
            cfg_reg.p1      <= '0;
            cfg_reg.p2      <= '0;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_FOCAL_X: cfg_reg.focal_x <= pwdata[23:0];
                REG_FOCAL_Y: cfg_reg.focal_y <= pwdata[23:0];
                REG_PP:
                begin
                    cfg_reg.cx <= pwdata[31:16];
                    cfg_reg.cy <= pwdata[15:0];
                end
                REG_K1:      cfg_reg.k1 <= pwdata[23:0];
                REG_K2:      cfg_reg.k2 <= pwdata[23:0];
                REG_K3:      cfg_reg.k3 <= pwdata[23:0];
                REG_P1:      cfg_reg.p1 <= pwdata[23:0];
                REG_P2:      cfg_reg.p2 <= pwdata[23:0];
                default:     ;
            endcase
        end
    end

    // register readback
    always_comb
    begin
        case (reg_idx)
            REG_FOCAL_X: prdata = {8'h00, cfg_reg.focal_x};
            REG_FOCAL_Y: prdata = {8'h00, cfg_reg.focal_y};
            REG_PP:      prdata = {cfg_reg.cx, cfg_reg.cy};
            REG_K1:      prdata = {8'h00, cfg_reg.k1};
            REG_K2:      prdata = {8'h00, cfg_reg.k2};
            REG_K3:      prdata = {8'h00, cfg_reg.k3};
            REG_P1:      prdata = {8'h00, cfg_reg.p1};
            REG_P2:      prdata = {8'h00, cfg_reg.p2};
            default:     prdata = '0;
        endcase
    end

    luo_ctrl #(
        .ITERATIONS (ITERATIONS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    luo_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .cfg          (cfg_reg),
        .x_pixel      (x_pixel),
        .y_pixel      (y_pixel),
        .out_stall    (out_stall),
        .out_valid    (out_valid),
        .corrected_x  (corrected_x),
        .corrected_y  (corrected_y),
        .out_of_range (out_of_range)
    );

endmodule

/* test/lens_point_undistort_tb.sv */
module lens_point_undistort_tb;
    import luo_pkg::*;

    localparam int ITERS = 10;
    localparam int RAND_WORDS = 2000;
    localparam longint CYCLE_LIMIT = 64'd12000000;

    // register indexes
    typedef enum int {
        REG_FOCAL_X = 0,
        REG_FOCAL_Y = 1,
        REG_PRINCIPAL = 2,
        REG_K1 = 3,
        REG_K2 = 4,
        REG_K3 = 5,
        REG_P1 = 6,
        REG_P2 = 7
    } reg_idx_t;

    // idle phases
    typedef enum int {
        PH_NONE,
        PH_SEND_IDLE,
        PH_RECV_STALL,
        PH_BOTH
    } phase_t;

    typedef struct {
        logic signed [19:0] cx;
        logic signed [19:0] cy;
        logic               oor;
    } point_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [4:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [15:0] x_pixel = '0, y_pixel = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic signed [19:0] corrected_x, corrected_y;
    logic out_of_range;

    // shadow of the configuration
    logic [23:0] m_fx, m_fy, m_k1, m_k2, m_k3, m_p1, m_p2;
    logic [31:0] m_pp;

    point_t expected_points[$];
    int errors = 0;
    int checked = 0;
    int flagged = 0;
    longint cycles = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;

    lens_point_undistort #(.ITERATIONS(ITERS)) dut (.*);

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("Simulation FAILED");
            $finish;
        end
    end

    // fixed-point helpers
    function automatic logic signed [31:0] clamp32(input logic signed [127:0] v, ref bit fl);
        if (v > 128'sd2147483647)
        begin
            fl = 1'b1;
            return 32'sh7fffffff;
        end
        if (v < -128'sd2147483648)
        begin
            fl = 1'b1;
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    function automatic logic signed [31:0] fmul(input logic signed [31:0] a,
                                                 input logic signed [31:0] b, ref bit fl);
        logic signed [127:0] p;
        p = (128'(a) * 128'(b) + (128'sd1 <<< 27)) >>> 28;
        return clamp32(p, fl);
    endfunction

    function automatic logic signed [127:0] quot_tz(input logic signed [127:0] n,
                                                     input logic signed [127:0] d);
        if (n >= 0) return n / d;
        return -((-n) / d);
    endfunction

    function automatic logic signed [31:0] to_norm(input logic [15:0] pix,
                                                    input logic [15:0] c,
                                                    input logic [23:0] f, ref bit fl);
        logic signed [127:0] d;
        d = 128'(pix) - 128'(c);
        if (f == 0)
        begin
            if (d == 0) return 0;
            fl = 1'b1;
            return (d > 0) ? 32'sh7fffffff : 32'sh80000000;
        end
        return clamp32(quot_tz(d <<< 32, 128'(f)), fl);
    endfunction

    function automatic logic signed [19:0] to_pix(input logic signed [31:0] v,
                                                   input logic [23:0] f,
                                                   input logic [15:0] c, ref bit fl);
        logic signed [127:0] r;
        r = (128'(v) * $signed(128'(f)) + $signed(128'(c) <<< 32)
             + (128'sd1 <<< 31)) >>> 32;
        if (r > 128'sd524287)
        begin
            fl = 1'b1;
            r = 524287;
        end
        if (r < -128'sd524288)
        begin
            fl = 1'b1;
            r = -524288;
        end
        return r[19:0];
    endfunction

    // predicts the undistorted point from the shadow configuration
    function automatic point_t undistort(input logic [15:0] xp, input logic [15:0] yp);
        bit fl;
        logic signed [31:0] k1, k2, k3, p1, p2, x0, y0, x, y;
        logic signed [31:0] xx, yy, xy, r2, r4, r6, xy2, den, dx, dy, nx, ny;
        point_t r;
        fl = 0;
        k1 = {m_k1, 8'd0};
        k2 = {m_k2, 8'd0};
        k3 = {m_k3, 8'd0};
        p1 = {m_p1, 8'd0};
        p2 = {m_p2, 8'd0};
        x0 = to_norm(xp, m_pp[31:16], m_fx, fl);
        y0 = to_norm(yp, m_pp[15:0], m_fy, fl);
        x = x0;
        y = y0;
        for (int i = 0; i < ITERS; i++)
        begin
            xx = fmul(x, x, fl);
            yy = fmul(y, y, fl);
            xy = fmul(x, y, fl);
            r2 = clamp32(128'(xx) + 128'(yy), fl);
            r4 = fmul(r2, r2, fl);
            r6 = fmul(r4, r2, fl);
            xy2 = clamp32(2 * 128'(xy), fl);
            den = clamp32((128'sd1 <<< 28) + 128'(fmul(k1, r2, fl))
                          + 128'(fmul(k2, r4, fl)) + 128'(fmul(k3, r6, fl)), fl);
            dx = clamp32(128'(fmul(p1, xy2, fl))
                         + 128'(fmul(p2, clamp32(128'(r2) + 2 * 128'(xx), fl), fl)), fl);
            dy = clamp32(128'(fmul(p1, clamp32(128'(r2) + 2 * 128'(yy), fl), fl))
                         + 128'(fmul(p2, xy2, fl)), fl);
            nx = clamp32(128'(x0) - 128'(dx), fl);
            ny = clamp32(128'(y0) - 128'(dy), fl);
            if (den <= 0)
            begin
                fl = 1'b1;
                x = nx;
                y = ny;
            end
            else
            begin
                x = clamp32(quot_tz(128'(nx) <<< 28, 128'(den)), fl);
                y = clamp32(quot_tz(128'(ny) <<< 28, 128'(den)), fl);
            end
        end
        r.cx = to_pix(x, m_fx, m_pp[31:16], fl);
        r.cy = to_pix(y, m_fy, m_pp[15:0], fl);
        r.oor = fl;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch on word %0d: %s got %0d expected %0d", checked, what, got, want);
        errors++;
    endtask

    // output monitor
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_points.size() == 0)
            begin
                report_mismatch("unexpected output word", 1, 0);
            end
            else
            begin
                point_t e;
                e = expected_points.pop_front();
                if (corrected_x !== e.cx) report_mismatch("corrected_x", corrected_x, e.cx);
                if (corrected_y !== e.cy) report_mismatch("corrected_y", corrected_y, e.cy);
                if (out_of_range !== e.oor)
                    report_mismatch("out_of_range", out_of_range, e.oor);
                if (e.oor) flagged++;
            end
            checked++;
        end
    end

    // receiver stall
    always @(posedge clk)
        out_stall <= ($urandom_range(99) < recv_stall_pct);

    task automatic write_reg(input reg_idx_t idx, input logic [31:0] val);
        @(posedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= 5'(4 * int'(idx));
        pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_FOCAL_X: m_fx = val[23:0];
            REG_FOCAL_Y: m_fy = val[23:0];
            REG_PRINCIPAL: m_pp = val;
            REG_K1: m_k1 = val[23:0];
            REG_K2: m_k2 = val[23:0];
            REG_K3: m_k3 = val[23:0];
            REG_P1: m_p1 = val[23:0];
            default: m_p2 = val[23:0];
        endcase
    endtask

    // send one word, optionally with a known result
    task automatic send_point(input logic [15:0] xp, input logic [15:0] yp,
                              input bit known, input point_t want);
        point_t p;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        p = undistort(xp, yp);
        if (known && (p.cx !== want.cx || p.cy !== want.cy || p.oor !== want.oor))
            $display("note: table row differs from predictor for %0d,%0d", xp, yp);
        in_valid <= 1'b1;
        x_pixel <= xp;
        y_pixel <= yp;
        do @(posedge clk); while (in_stall);
        expected_points.insert(expected_points.size(), known ? want : p);
    endtask

    // drop valid after the last word, then wait for all results
    task automatic drain(input int extra);
        in_valid <= 1'b0;
        while (expected_points.size() != 0) @(posedge clk);
        repeat (extra) @(posedge clk);
    endtask

    task automatic rand_config(input bit mild);
        logic [23:0] f;
        f = mild ? 24'($urandom_range(20000, 300)) : 24'($urandom_range(16777215, 1));
        write_reg(REG_FOCAL_X, f);
        write_reg(REG_FOCAL_Y, mild ? f + 24'($urandom_range(200)) : $urandom);
        write_reg(REG_PRINCIPAL, $urandom);
        write_reg(REG_K1, mild ? 32'($signed(24'($urandom_range(400000)) - 24'd200000))
                               : $urandom);
        write_reg(REG_K2, mild ? 32'($signed(24'($urandom_range(80000)) - 24'd40000))
                               : $urandom);
        write_reg(REG_K3, mild ? 32'($signed(24'($urandom_range(20000)) - 24'd10000))
                               : $urandom);
        write_reg(REG_P1, mild ? 32'($signed(24'($urandom_range(4000)) - 24'd2000))
                               : $urandom);
        write_reg(REG_P2, mild ? 32'($signed(24'($urandom_range(4000)) - 24'd2000))
                               : $urandom);
    endtask

    typedef struct {
        logic [15:0] xp;
        logic [15:0] yp;
        bit          known;
        point_t      want;
    } stim_row_t;

    stim_row_t dir_rows[$];

    initial
    begin
        phase_t ph;
        point_t none;
        m_fx = 256; m_fy = 256; m_pp = 0;
        m_k1 = 0; m_k2 = 0; m_k3 = 0; m_p1 = 0; m_p2 = 0;
        none = '{cx: 0, cy: 0, oor: 0};
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // after reset: identity mapping at focal 1.0 with no distortion;
        // the second point has r2 = 5.0, so r4 saturates and the flag is set
        dir_rows = '{
            '{16'd0, 16'd0, 1, '{0, 0, 0}},
            '{16'd16, 16'd32, 1, '{16, 32, 1}},
            '{16'd1, 16'd2, 0, none},
            '{16'hffff, 16'hffff, 0, none},
            '{16'h8000, 16'h0001, 0, none}
        };
        foreach (dir_rows[i])
            send_point(dir_rows[i].xp, dir_rows[i].yp, dir_rows[i].known, dir_rows[i].want);
        drain(1100);

        // zero focal length: normalisation saturates off the principal point, flag set
        write_reg(REG_FOCAL_X, 0);
        write_reg(REG_FOCAL_Y, 0);
        write_reg(REG_PRINCIPAL, 32'h0100_0100);
        send_point(16'h0100, 16'h0100, 1, '{16'sd256, 16'sd256, 1'b0});
        send_point(16'hffff, 16'h0000, 0, none);
        send_point(16'h0000, 16'hffff, 0, none);
        drain(1100);

        // strongly negative k1: non-positive denominator
        write_reg(REG_FOCAL_X, 24'hffffff);
        write_reg(REG_FOCAL_Y, 24'd1);
        write_reg(REG_K1, 32'h00800000);
        write_reg(REG_K2, 32'h007fffff);
        write_reg(REG_K3, 32'h00800000);
        write_reg(REG_P1, 32'h007fffff);
        write_reg(REG_P2, 32'h00800000);
        send_point(16'hffff, 16'hffff, 0, none);
        send_point(16'h0000, 16'h0000, 0, none);
        send_point(16'h00f0, 16'h0300, 0, none);
        send_point(16'h5555, 16'haaaa, 0, none);
        drain(1100);

        // random part in idle phases, configuration changed between chunks
        for (int chunk = 0; chunk < 20; chunk++)
        begin
            ph = phase_t'(chunk % 4);
            send_idle_pct = (ph == PH_SEND_IDLE) ? 71 : (ph == PH_BOTH) ? 27 : 0;
            recv_stall_pct = (ph == PH_RECV_STALL) ? 71 : (ph == PH_BOTH) ? 27 : 0;
            rand_config(chunk % 5 != 4);
            for (int i = 0; i < RAND_WORDS / 20; i++)
            begin
                if ($urandom_range(9) == 0)
                    send_point(16'($urandom), 16'($urandom), 0, none);
                else
                    send_point(m_pp[31:16] + 16'($urandom_range(2000)) - 16'd1000,
                               m_pp[15:0] + 16'($urandom_range(2000)) - 16'd1000, 0, none);
            end
            drain(1100);
        end
        recv_stall_pct = 0;
        drain(1100);

        $display("checked %0d corrected points over 20 register settings, %0d flagged",
                 checked, flagged);
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

/* filelist.f */
design/luo_pkg.sv
design/luo_div.sv
design/luo_datapath.sv
design/luo_ctrl.sv
design/lens_point_undistort.sv
test/lens_point_undistort_tb.sv
